>>> hdl/b64e_pkg.sv
package b64e_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [5:0] SIX_MASK = 6'h3F;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PHASE_0 = 2'd0,
    PHASE_1 = 2'd1,
    PHASE_2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } byte_req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       run_end;
    logic       message_end;
  } char_req_t;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last;
    logic            ends_message;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v & SIX_MASK};
    if (w < 8'd26) begin
      return w + 8'd65;
    end else if (w < 8'd52) begin
      return w + 8'd71;
    end else if (w < 8'd62) begin
      return w - 8'd4;
    end else if (w == 8'd62) begin
      return 8'd43;
    end else begin
      return 8'd47;
    end
  endfunction

endpackage

>>> hdl/b64e_front.sv
module b64e_front
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  byte_req_t byte_req,
  input  logic      queue_full,
  output logic      push,
  output job_t      job
);

  phase_t     phase, phase_next;
  logic [3:0] leftover, leftover_next;

  assign byte_ready = !queue_full;
  assign push       = byte_valid && !queue_full;

  always_comb begin
    logic [7:0] b;
    logic       fin;
    b             = byte_req.data_byte;
    fin           = byte_req.is_final;
    job.chars     = {PAD_CHAR, PAD_CHAR, PAD_CHAR, PAD_CHAR};
    job.ends_message = fin;
    phase_next    = phase;
    leftover_next = leftover;
    case (phase)
      PHASE_1: begin
        job.chars[0]  = sextet_char({leftover[1:0], b[7:4]});
        job.chars[1]  = sextet_char({b[3:0], 2'b00});
        job.last      = fin ? 2'd2 : 2'd0;
        phase_next    = fin ? PHASE_0 : PHASE_2;
        leftover_next = fin ? 4'd0 : b[3:0];
      end
      PHASE_2: begin
        job.chars[0]  = sextet_char({leftover, b[7:6]});
        job.chars[1]  = sextet_char(b[5:0]);
        job.last      = 2'd1;
        phase_next    = PHASE_0;
        leftover_next = 4'd0;
      end
      default: begin
        job.chars[0]  = sextet_char(b[7:2]);
        job.chars[1]  = sextet_char({b[1:0], 4'b0000});
        job.last      = fin ? 2'd3 : 2'd0;
        phase_next    = fin ? PHASE_0 : PHASE_1;
        leftover_next = fin ? 4'd0 : {2'b00, b[1:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PHASE_0;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

>>> hdl/b64e_queue.sv
module b64e_queue
  import b64e_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  job_t                   slots [QUEUE_DEPTH];
  logic [PtrW-1:0]        wr_ptr;
  logic [PtrW-1:0]        rd_ptr;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count;

  assign full       = count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid)) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count missed a push");
`endif

endmodule

>>> hdl/b64e_back.sv
module b64e_back
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      char_valid,
  input  logic      char_ready,
  output char_req_t char_req
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!char_valid || char_ready);
  assign at_last = idx == head_job.last;
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= 2'd0;
      char_valid <= 1'b0;
    end else begin
      if (load) begin
        char_valid <= 1'b1;
        idx        <= at_last ? 2'd0 : idx + 2'd1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_req.char_code   <= head_job.chars[idx];
      char_req.run_end     <= at_last;
      char_req.message_end <= at_last && head_job.ends_message;
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head_job.last) else $error("index past end of job");
  a_idx_rest: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == 2'd0) else $error("index not at rest when idle");
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_req.message_end) |-> char_req.run_end)
    else $error("message end without run end");
`endif

endmodule

>>> hdl/base64_stream_encoder.sv
// channel | handshake              | payload
// byte    | byte_valid, byte_ready | byte_req  (data_byte, is_final)
// char    | char_valid, char_ready | char_req  (char_code, run_end, message_end)
//
// One byte is taken per cycle while the two-entry job queue has room.
// The back end sends one character per cycle while char_ready is high, so a byte yields one to four
// characters at the output (four characters for every three bytes on a long stream).
// The first character of a byte passes through the job queue slot, then the back end's output register.
// Reset is synchronous and clears phase, queue and output valid.
// A stall on char_ready backs up into the queue, then drops byte_ready.
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  byte_req_t byte_req,
  output logic      char_valid,
  input  logic      char_ready,
  output char_req_t char_req
);

  logic push;
  logic pop;
  logic queue_full;
  logic head_valid;
  job_t push_job;
  job_t head_job;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_req   (byte_req),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_req   (char_req)
  );

endmodule
